// ===== sv/qmn_pkg.sv =====
// Shared types and widths for the normalized quaternion product pipeline.
`default_nettype none
package qmn_pkg;
  localparam int COMP_W  = 16;   // input and result component width
  localparam int PROD_W  = 34;   // signed product component, Q6.28
  localparam int MAG_W   = 33;   // magnitude of a product component
  localparam int SQ_W    = 66;   // squared magnitude
  localparam int SUM_W   = 67;   // sum of the four squares
  localparam int ACC_W   = 100;  // signed remainder and cross term of the root search
  localparam int K_W     = 15;   // result magnitude, 0..16384
  localparam int LANES   = 4;
  localparam int STAGES  = 15;   // one root-search stage per result bit

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic        [SUM_W-1:0]  sum_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef struct packed {
    comp_t ax;
    comp_t ay;
    comp_t az;
    comp_t aw;
    comp_t bx;
    comp_t by;
    comp_t bz;
    comp_t bw;
  } quat_pair_t;

  typedef struct packed {
    acc_t           r;
    acc_t           q;
    logic [K_W-1:0] k;
  } lane_t;

  typedef struct packed {
    logic                  valid;
    logic                  zero;
    logic [LANES-1:0]      neg;
    sum_t                  s;
    lane_t [LANES-1:0]     lane;
  } norm_t;
endpackage
`default_nettype wire

// ===== sv/qmn_product.sv =====
// Two-stage Hamilton product b times a: sixteen 16x16 products, then the sums.
`default_nettype none
module qmn_product (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               en,
  input  wire logic                               in_valid,
  input  wire qmn_pkg::quat_pair_t                qp,
  output logic                                    p_valid,
  output qmn_pkg::prod_t [qmn_pkg::LANES-1:0]     p
);
  logic signed [31:0] a_v [4];
  logic signed [31:0] b_v [4];
  logic signed [31:0] mul_r [4][4];
  logic               v1_r;
  logic               v2_r;
  qmn_pkg::prod_t [qmn_pkg::LANES-1:0] p_r;

  assign a_v[0] = 32'(qp.ax);
  assign a_v[1] = 32'(qp.ay);
  assign a_v[2] = 32'(qp.az);
  assign a_v[3] = 32'(qp.aw);
  assign b_v[0] = 32'(qp.bx);
  assign b_v[1] = 32'(qp.by);
  assign b_v[2] = 32'(qp.bz);
  assign b_v[3] = 32'(qp.bw);

  // Form all cross products a_i * b_j
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          mul_r[i][j] <= a_v[i] * b_v[j];
        end
      end
    end
  end

  // Combine products into the four components
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= qmn_pkg::prod_t'(mul_r[0][3]) + qmn_pkg::prod_t'(mul_r[3][0])
              + qmn_pkg::prod_t'(mul_r[2][1]) - qmn_pkg::prod_t'(mul_r[1][2]);
      p_r[1] <= qmn_pkg::prod_t'(mul_r[1][3]) + qmn_pkg::prod_t'(mul_r[3][1])
              + qmn_pkg::prod_t'(mul_r[0][2]) - qmn_pkg::prod_t'(mul_r[2][0]);
      p_r[2] <= qmn_pkg::prod_t'(mul_r[2][3]) + qmn_pkg::prod_t'(mul_r[3][2])
              + qmn_pkg::prod_t'(mul_r[1][0]) - qmn_pkg::prod_t'(mul_r[0][1]);
      p_r[3] <= qmn_pkg::prod_t'(mul_r[3][3]) - qmn_pkg::prod_t'(mul_r[0][0])
              - qmn_pkg::prod_t'(mul_r[1][1]) - qmn_pkg::prod_t'(mul_r[2][2]);
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  assign p_valid = v2_r;
  assign p       = p_r;
endmodule
`default_nettype wire

// ===== sv/qmn_energy.sv =====
// Three stages: squared magnitudes, their sum, and the root-search start values.
`default_nettype none
module qmn_energy (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               en,
  input  wire logic                               p_valid,
  input  wire qmn_pkg::prod_t [qmn_pkg::LANES-1:0] p,
  output qmn_pkg::norm_t                          init
);
  logic [qmn_pkg::MAG_W-1:0] mag [qmn_pkg::LANES];
  logic [qmn_pkg::SQ_W-1:0]  sq_r  [qmn_pkg::LANES];
  logic [qmn_pkg::SQ_W-1:0]  sq2_r [qmn_pkg::LANES];
  logic [qmn_pkg::LANES-1:0] neg_r;
  logic [qmn_pkg::LANES-1:0] neg2_r;
  qmn_pkg::sum_t             s_r;
  logic                      va_r;
  logic                      vb_r;
  qmn_pkg::norm_t            init_r;

  always_comb begin
    for (int i = 0; i < qmn_pkg::LANES; i++) begin
      mag[i] = p[i][qmn_pkg::PROD_W-1] ? qmn_pkg::MAG_W'(-p[i])
                                       : qmn_pkg::MAG_W'(p[i]);
    end
  end

  // Square each magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < qmn_pkg::LANES; i++) begin
        sq_r[i]  <= qmn_pkg::SQ_W'(mag[i]) * qmn_pkg::SQ_W'(mag[i]);
        neg_r[i] <= p[i][qmn_pkg::PROD_W-1];
      end
    end
  end

  // Sum the squares, hold each square for its own lane
  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= qmn_pkg::SUM_W'(sq_r[0]) + qmn_pkg::SUM_W'(sq_r[1])
           + qmn_pkg::SUM_W'(sq_r[2]) + qmn_pkg::SUM_W'(sq_r[3]);
      sq2_r  <= sq_r;
      neg2_r <= neg_r;
    end
  end

  // Advance valid bits; start values with k = 0: r = P^2 * 2^30 - S, q = -S
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r         <= 1'b0;
      vb_r         <= 1'b0;
      init_r.valid <= 1'b0;
    end else if (en) begin
      va_r         <= p_valid;
      vb_r         <= va_r;
      init_r.valid <= vb_r;
      init_r.zero  <= (s_r == '0);
      init_r.neg   <= neg2_r;
      init_r.s     <= s_r;
      for (int i = 0; i < qmn_pkg::LANES; i++) begin
        init_r.lane[i].r <= qmn_pkg::acc_t'({4'b0, sq2_r[i], 30'b0})
                          - qmn_pkg::acc_t'({33'b0, s_r});
        init_r.lane[i].q <= -qmn_pkg::acc_t'({33'b0, s_r});
        init_r.lane[i].k <= '0;
      end
    end
  end

  assign init = init_r;
endmodule
`default_nettype wire

// ===== sv/qmn_norm_stage.sv =====
// One root-search stage: decide one bit of each result magnitude.
`default_nettype none
module qmn_norm_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic [3:0]     bit_idx,
  input  wire qmn_pkg::norm_t d_in,
  output qmn_pkg::norm_t      d_out
);
  qmn_pkg::norm_t d_nxt;
  qmn_pkg::norm_t d_r;
  qmn_pkg::acc_t  s_ext;
  qmn_pkg::acc_t  trial [qmn_pkg::LANES];
  logic [6:0]     sh_q;
  logic [6:0]     sh_s;
  logic [6:0]     sh_a;

  assign s_ext = qmn_pkg::acc_t'({33'b0, d_in.s});
  assign sh_q  = 7'(bit_idx) + 7'd2;
  assign sh_s  = {2'b0, bit_idx, 1'b0} + 7'd2;
  assign sh_a  = 7'(bit_idx) + 7'd1;

  // Try setting the bit: (2k-1)^2 grows by 2^(j+2)(2k-1) + 2^(2j+2)
  always_comb begin
    d_nxt = d_in;
    for (int i = 0; i < qmn_pkg::LANES; i++) begin
      trial[i] = d_in.lane[i].r - (d_in.lane[i].q <<< sh_q) - (s_ext <<< sh_s);
      if (!trial[i][qmn_pkg::ACC_W-1]) begin
        d_nxt.lane[i].r = trial[i];
        d_nxt.lane[i].q = d_in.lane[i].q + (s_ext <<< sh_a);
        d_nxt.lane[i].k = d_in.lane[i].k | (qmn_pkg::K_W'(1) << bit_idx);
      end
    end
  end

  // Hold the item while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;
endmodule
`default_nettype wire

// ===== sv/quaternion_multiply_normalize.sv =====
// Pipeline: 21 register stages (2 product, 3 energy, 15 root-search, 1 output).
// Throughput: one item per cycle; the whole pipeline advances on one enable,
// held only while a result waits at the output.
// Reset: synchronous active-low rst_n clears all valid bits; no other state.
`default_nettype none
module quaternion_multiply_normalize (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic signed [15:0]    in_a_x,
  input  wire logic signed [15:0]    in_a_y,
  input  wire logic signed [15:0]    in_a_z,
  input  wire logic signed [15:0]    in_a_w,
  input  wire logic signed [15:0]    in_b_x,
  input  wire logic signed [15:0]    in_b_y,
  input  wire logic signed [15:0]    in_b_z,
  input  wire logic signed [15:0]    in_b_w,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [15:0]         out_r_x,
  output logic signed [15:0]         out_r_y,
  output logic signed [15:0]         out_r_z,
  output logic signed [15:0]         out_r_w,
  output logic                       out_zero_magnitude
);
  logic                                   en;
  qmn_pkg::quat_pair_t                    qp;
  logic                                   p_valid;
  qmn_pkg::prod_t [qmn_pkg::LANES-1:0]    p;
  qmn_pkg::norm_t                         stg [qmn_pkg::STAGES+1];
  qmn_pkg::norm_t                         last;
  qmn_pkg::comp_t                         res_nxt [qmn_pkg::LANES];
  qmn_pkg::comp_t                         res_r   [qmn_pkg::LANES];
  logic                                   zero_r;
  logic                                   out_valid_r;

  // Advance everything unless a result is stuck at the output
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  assign qp.ax = in_a_x;
  assign qp.ay = in_a_y;
  assign qp.az = in_a_z;
  assign qp.aw = in_a_w;
  assign qp.bx = in_b_x;
  assign qp.by = in_b_y;
  assign qp.bz = in_b_z;
  assign qp.bw = in_b_w;

  qmn_product u_product (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .qp       (qp),
    .p_valid  (p_valid),
    .p        (p)
  );

  qmn_energy u_energy (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .p_valid (p_valid),
    .p       (p),
    .init    (stg[0])
  );

  // Root search, most significant bit first
  for (genvar g = 0; g < qmn_pkg::STAGES; g++) begin : g_norm
    qmn_norm_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .bit_idx (4'(qmn_pkg::STAGES - 1 - g)),
      .d_in    (stg[g]),
      .d_out   (stg[g+1])
    );
  end

  assign last = stg[qmn_pkg::STAGES];

  // Apply sign, force zeros on zero magnitude
  always_comb begin
    for (int i = 0; i < qmn_pkg::LANES; i++) begin
      if (last.zero) begin
        res_nxt[i] = '0;
      end else if (last.neg[i]) begin
        res_nxt[i] = -qmn_pkg::comp_t'({1'b0, last.lane[i].k});
      end else begin
        res_nxt[i] = qmn_pkg::comp_t'({1'b0, last.lane[i].k});
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= res_nxt;
      zero_r <= last.zero;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last.valid;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_r_x            = res_r[0];
  assign out_r_y            = res_r[1];
  assign out_r_z            = res_r[2];
  assign out_r_w            = res_r[3];
  assign out_zero_magnitude = zero_r;
endmodule
`default_nettype wire

// ===== sv/qmn_checker.sv =====
// Port-level checker for the normalized quaternion product, bound to the top level.
`default_nettype none
module qmn_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] out_r_x,
  input wire logic signed [15:0] out_r_y,
  input wire logic signed [15:0] out_r_z,
  input wire logic signed [15:0] out_r_w,
  input wire logic               out_zero_magnitude
);
  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_r_x) && $stable(out_r_y)
      && $stable(out_r_z) && $stable(out_r_w) && $stable(out_zero_magnitude))
    else $error("stalled result changed");

  // Input is taken whenever the output can move
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output side");

  // Zero magnitude forces zero components
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_magnitude |->
      out_r_x == 16'sd0 && out_r_y == 16'sd0 && out_r_z == 16'sd0 && out_r_w == 16'sd0)
    else $error("zero magnitude with nonzero result");

  // Normalized components stay within unit range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_r_x <= 16'sd16384 && out_r_x >= -16'sd16384
      && out_r_y <= 16'sd16384 && out_r_y >= -16'sd16384
      && out_r_z <= 16'sd16384 && out_r_z >= -16'sd16384
      && out_r_w <= 16'sd16384 && out_r_w >= -16'sd16384)
    else $error("result component out of range");
endmodule

bind quaternion_multiply_normalize qmn_checker u_qmn_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_r_x            (out_r_x),
  .out_r_y            (out_r_y),
  .out_r_z            (out_r_z),
  .out_r_w            (out_r_w),
  .out_zero_magnitude (out_zero_magnitude)
);
`default_nettype wire
